// File: design/ets_pkg.sv
package ets_pkg;

    // Fixed formats
    localparam int MAX_TERMS      = 64;
    localparam int TERM_FRAC_BITS = 40;
    localparam int X_W            = 31;
    localparam int X_FRAC_BITS    = 28;
    localparam int OUT_FRAC_BITS  = 24;
    localparam int NT_W           = 7;
    localparam int EPS_IN_W       = 25;
    localparam int OUT_W          = 32;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 25;

    // Terms peak near 416 for x just under 8, the sum stays below 2981
    localparam int TERM_W  = TERM_FRAC_BITS + 10;
    localparam int SUM_W   = TERM_FRAC_BITS + 13;
    localparam int TLO_W   = (TERM_W + 1) / 2;
    localparam int THI_W   = TERM_W - TLO_W;
    localparam int PLO_W   = X_W + TLO_W;
    localparam int PHI_W   = X_W + THI_W;
    localparam int PROD_W  = X_W + TERM_W;
    localparam int DVD_W   = PROD_W - X_FRAC_BITS;
    localparam int Q_W     = SUM_W - (TERM_FRAC_BITS - OUT_FRAC_BITS);

    // Divider: restoring, several quotient bits per cycle
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYCLES = (DVD_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DQ_W       = DIV_CYCLES * DIV_STEPS;
    localparam int DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam logic [NT_W-1:0] CAP =
        (MAX_TERMS > 127) ? NT_W'(127) : NT_W'(MAX_TERMS);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_N_TERMS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS     = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic div_load;
        logic div_step;
        logic update;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic finish;
    } t_stat;

endpackage

// File: design/exp_taylor_series.sv
// Maclaurin-series e^x for an unsigned Q3.28 argument. Each word on the
// input gives one result word: the sum of n_terms terms in unsigned Q8.24
// (saturated to all ones with overflow set) and the first term index whose
// term is at or below eps_threshold (Q1.24), or 64 if none is. One item is
// worked at a time. Each term is worked in steps: the 31 x 50-bit multiply,
// split into two 31 x 25-bit halves, forming the dividend, the divider,
// which resolves eight quotient bits a cycle, and the update of the sum.
// The block runs max(n_terms - 1, terms needed, capped at 64) terms, at
// least one. The next word is taken while a finished result still waits
// on the output. Registers must be written only while the block is idle;
// the block itself does not enforce this.
module exp_taylor_series import ets_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [X_W-1:0]        i_x_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [OUT_W-1:0]      o_sum_value,
    output logic [NT_W-1:0]       o_terms_needed,
    output logic                  o_overflow
);

    logic [NT_W-1:0]     r_n_terms;
    logic [EPS_IN_W-1:0] r_eps;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_sum_value;
    logic [NT_W-1:0]     r_terms_needed;
    logic                r_overflow;

    t_cmd             cmd;
    t_stat            stat;
    logic             idle;
    logic             out_free;
    logic [OUT_W-1:0] dp_sum;
    logic [NT_W-1:0]  dp_needed;
    logic             dp_ovf;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_terms <= NT_W'(24);
            r_eps     <= EPS_IN_W'(17);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_N_TERMS: r_n_terms <= i_cfg_wdata[NT_W-1:0];
                CFG_EPS:     r_eps     <= i_cfg_wdata[EPS_IN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !idle;

    ets_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_idle     (idle),
        .o_cmd      (cmd)
    );

    ets_dpath u_dpath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_x_value      (i_x_value),
        .i_n_terms      (r_n_terms),
        .i_eps          (r_eps),
        .o_stat         (stat),
        .o_sum_value    (dp_sum),
        .o_terms_needed (dp_needed),
        .o_overflow     (dp_ovf)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_sum_value    <= dp_sum;
            r_terms_needed <= dp_needed;
            r_overflow     <= dp_ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sum_value    = r_sum_value;
    assign o_terms_needed = r_terms_needed;
    assign o_overflow     = r_overflow;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result word overwritten while held");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> (o_sum_value == '1))
        else $error("overflow without saturated sum");

    a_needed_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_terms_needed <= CAP))
        else $error("term count above cap");

endmodule

// File: design/ets_ctrl.sv
module ets_ctrl import ets_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output logic  o_idle,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MLO  = 7'b0000010,
        S_MHI  = 7'b0000100,
        S_DLD  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_UPD  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [DCNT_W-1:0] r_cnt, n_cnt;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MLO;
                end
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_DLD;
            end
            S_DLD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_CYCLES - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = i_stat.finish ? S_DONE : S_MLO;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: design/ets_dpath.sv
module ets_dpath import ets_pkg::*; (
    input  logic                i_clk,
    input  t_cmd                i_cmd,
    input  logic [X_W-1:0]      i_x_value,
    input  logic [NT_W-1:0]     i_n_terms,
    input  logic [EPS_IN_W-1:0] i_eps,
    output t_stat               o_stat,
    output logic [OUT_W-1:0]    o_sum_value,
    output logic [NT_W-1:0]     o_terms_needed,
    output logic                o_overflow
);

    localparam logic [TERM_W-1:0] ONE = TERM_W'(1) << TERM_FRAC_BITS;

    logic [X_W-1:0]    r_x;
    logic [TERM_W-1:0] r_term;
    logic [SUM_W-1:0]  r_sum;
    logic [NT_W-1:0]   r_idx;
    logic [NT_W-1:0]   r_needed;
    logic              r_done;
    logic [PLO_W-1:0]  r_plo;
    logic [PHI_W-1:0]  r_phi;
    logic [DQ_W-1:0]   r_dq;
    logic [NT_W-1:0]   r_rem;

    logic [NT_W-1:0]   n_eff;
    logic [TERM_W-1:0] eps_ext;
    logic [TERM_W-1:0] q_term;
    logic              q_small;
    logic              hit;
    logic [PROD_W-1:0] prod;
    logic [DQ_W-1:0]   n_dq;
    logic [NT_W-1:0]   n_rem;
    logic [Q_W-1:0]    q_out;

    // Zero term count behaves as one
    assign n_eff   = (i_n_terms == '0) ? NT_W'(1) : i_n_terms;
    assign eps_ext = TERM_W'({i_eps, {(TERM_FRAC_BITS - OUT_FRAC_BITS){1'b0}}});

    // Full product from the two partial products
    assign prod = (PROD_W'(r_phi) << TLO_W) + PROD_W'(r_plo);

    // Restoring division by the term index, DIV_STEPS bits a cycle
    always_comb begin
        logic [NT_W:0] t;
        n_dq  = r_dq;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t    = {n_rem, n_dq[DQ_W-1]};
            n_dq = n_dq << 1;
            if (t >= {1'b0, r_idx}) begin
                n_rem   = NT_W'(t - {1'b0, r_idx});
                n_dq[0] = 1'b1;
            end else begin
                n_rem = t[NT_W-1:0];
            end
        end
    end

    // New term and its threshold test
    assign q_term  = r_dq[TERM_W-1:0];
    assign q_small = (q_term <= eps_ext);
    assign hit     = !r_done && (r_idx <= CAP) && q_small;

    // Stop once the summed terms are in and the count is settled
    assign o_stat.finish = (({1'b0, r_idx} + 1'b1) >= {1'b0, n_eff})
                         && (r_done || hit || (r_idx >= CAP));

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x      <= i_x_value;
            r_term   <= ONE;
            r_sum    <= SUM_W'(ONE);
            r_idx    <= NT_W'(1);
            r_done   <= i_eps[EPS_IN_W-1];
            r_needed <= i_eps[EPS_IN_W-1] ? '0 : CAP;
        end
        if (i_cmd.mul_lo) begin
            r_plo <= PLO_W'(r_x) * PLO_W'(r_term[TLO_W-1:0]);
        end
        if (i_cmd.mul_hi) begin
            r_phi <= PHI_W'(r_x) * PHI_W'(r_term[TERM_W-1:TLO_W]);
        end
        if (i_cmd.div_load) begin
            r_dq  <= DQ_W'(prod >> X_FRAC_BITS);
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_dq  <= n_dq;
            r_rem <= n_rem;
        end
        if (i_cmd.update) begin
            r_term <= q_term;
            if (r_idx < n_eff) begin
                r_sum <= r_sum + SUM_W'(q_term);
            end
            if (hit) begin
                r_needed <= r_idx;
                r_done   <= 1'b1;
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    // Q8.24 result with saturation
    assign q_out          = r_sum[SUM_W-1:TERM_FRAC_BITS-OUT_FRAC_BITS];
    assign o_overflow     = |q_out[Q_W-1:OUT_W];
    assign o_sum_value    = o_overflow ? '1 : q_out[OUT_W-1:0];
    assign o_terms_needed = r_needed;

endmodule

// File: tb/exp_taylor_series_tb.sv
`timescale 1ns / 1ps
module exp_taylor_series_tb;
    import ets_pkg::*;

    typedef enum logic [1:0] {JOB_X, JOB_CFG, JOB_DRAIN} t_job_kind;

    typedef struct {
        t_job_kind            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } t_job;

    typedef struct packed {
        logic [OUT_W-1:0] sum;
        logic [NT_W-1:0]  needed;
        logic             ovf;
    } t_exp_word;

    // watchdog covers the slowest item (127 terms) plus the longest stall
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int X_ITEMS         = 1250;
    localparam logic [63:0]    TERM_CLAMP = (64'd1 << 60) - 64'd1;
    localparam logic [X_W-1:0] X_MAX      = '1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [X_W-1:0]        i_x_value   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [OUT_W-1:0]      o_sum_value;
    logic [NT_W-1:0]       o_terms_needed;
    logic                  o_overflow;

    // register copies for prediction, reset values to start with
    logic [NT_W-1:0]     n_terms_cfg = NT_W'(24);
    logic [EPS_IN_W-1:0] eps_cfg     = EPS_IN_W'(17);

    t_job      x_jobs[$];
    t_exp_word exp_due[$];
    int        x_count     = 0;
    int        errors      = 0;
    int        stuck       = 0;
    int        idle_cycles = 0;
    int        gap_left    = 0;
    int        stall_left  = 0;
    logic      x_taken     = 1'b0;
    logic      quiet       = 1'b0;

    exp_taylor_series uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_x_value      (i_x_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sum_value    (o_sum_value),
        .o_terms_needed (o_terms_needed),
        .o_overflow     (o_overflow)
    );

    always #6 i_clk = ~i_clk;

    // Series sum and first term at or below the threshold, current settings
    function automatic t_exp_word taylor_predict(input logic [X_W-1:0] x);
        logic [63:0]     term;
        logic [63:0]     total;
        logic [63:0]     eps;
        logic [63:0]     q;
        logic [95:0]     prod;
        int unsigned     n;
        int unsigned     capv;
        int unsigned     last;
        int unsigned     k;
        logic [NT_W-1:0] needed;
        logic            met;
        t_exp_word       r;
        n    = (n_terms_cfg == 0) ? 1 : n_terms_cfg;
        capv = (MAX_TERMS > 127) ? 127 : MAX_TERMS;
        last = (n > capv) ? n : capv;
        eps  = 64'(eps_cfg) << (TERM_FRAC_BITS - OUT_FRAC_BITS);
        term   = 64'd1 << TERM_FRAC_BITS;
        total  = term;
        needed = NT_W'(capv);
        met    = (term <= eps);
        if (met) needed = '0;
        for (k = 1; k <= last; k++) begin
            prod = (96'(term) * 96'(x)) >> X_FRAC_BITS;
            term = (prod > 96'(TERM_CLAMP)) ? TERM_CLAMP : prod[63:0];
            term = term / 64'(k);
            if (k < n) total = total + term;
            if (!met && k <= capv && term <= eps) begin
                needed = NT_W'(k);
                met    = 1'b1;
            end
        end
        q      = total >> (TERM_FRAC_BITS - OUT_FRAC_BITS);
        r.ovf  = (q > 64'hFFFF_FFFF);
        r.sum  = r.ovf ? '1 : q[OUT_W-1:0];
        r.needed = needed;
        return r;
    endfunction

    // Hold length: mostly short, now and then long
    function automatic int hold_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 99) < 55) return 0;
        return hold_len();
    endfunction

    function automatic logic [X_W-1:0] rand_x();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            case ($urandom_range(0, 2))
                0: return '0;
                1: return X_MAX;
                default: return X_W'(1) << $urandom_range(0, X_W - 1);
            endcase
        end
        if (pick < 3) return X_W'($urandom_range(0, 32'h1000_0000));
        return X_W'($urandom());
    endfunction

    task automatic add_x(input logic [X_W-1:0] x);
        t_job j;
        j.kind  = JOB_X;
        j.index = '0;
        j.data  = 32'(x);
        x_jobs.push_back(j);
        x_count++;
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        t_job j;
        j.kind  = JOB_CFG;
        j.index = idx;
        j.data  = val;
        x_jobs.push_back(j);
    endtask

    task automatic add_drain();
        t_job j;
        j.kind  = JOB_DRAIN;
        j.index = '0;
        j.data  = '0;
        x_jobs.push_back(j);
    endtask

    // Driver: argument words and register writes, changed on the falling edge
    always @(negedge i_clk) begin
        logic nv;
        logic we;
        t_job job;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_we   <= 1'b0;
        end else begin
            nv = i_in_valid && !x_taken;
            we = 1'b0;
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (x_jobs.size() != 0) begin
                    job = x_jobs[0];
                    case (job.kind)
                        JOB_X: begin
                            nv = 1'b1;
                            i_x_value <= job.data[X_W-1:0];
                            void'(x_jobs.pop_front());
                            gap_left = pick_gap();
                        end
                        JOB_CFG: begin
                            // only once the block has gone quiet
                            if (idle_cycles >= 4) begin
                                we = 1'b1;
                                i_cfg_index <= job.index;
                                i_cfg_wdata <= job.data[CFG_DATA_W-1:0];
                                if (job.index == CFG_N_TERMS)
                                    n_terms_cfg = job.data[NT_W-1:0];
                                else
                                    eps_cfg = job.data[EPS_IN_W-1:0];
                                void'(x_jobs.pop_front());
                            end
                        end
                        default: begin
                            if (idle_cycles >= 4) void'(x_jobs.pop_front());
                        end
                    endcase
                end
            end
            i_in_valid <= nv;
            i_cfg_we   <= we;
        end
    end

    // Result stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_left > 0)
                stall_left--;
            else if (!quiet && $urandom_range(0, 9) < 3)
                stall_left = hold_len();
            i_out_stall <= (stall_left > 0);
        end
    end

    // Monitor: predict on each accepted argument, check each result word
    always @(posedge i_clk) begin
        t_exp_word want;
        if (!i_rst_n) begin
            x_taken <= 1'b0;
        end else begin
            x_taken <= i_in_valid && !o_in_stall;
            if ($urandom_range(0, 399) == 0) quiet <= !quiet;
            if (o_out_valid && !i_out_stall) begin
                if (exp_due.size() == 0) begin
                    $display("%0t: unexpected word sum %h terms %0d ovf %b", $time,
                             o_sum_value, o_terms_needed, o_overflow);
                    errors++;
                end else begin
                    want = exp_due.pop_front();
                    if (o_sum_value !== want.sum) begin
                        $display("%0t: sum_value expected %h actual %h", $time,
                                 want.sum, o_sum_value);
                        errors++;
                    end
                    if (o_terms_needed !== want.needed) begin
                        $display("%0t: terms_needed expected %0d actual %0d", $time,
                                 want.needed, o_terms_needed);
                        errors++;
                    end
                    if (o_overflow !== want.ovf) begin
                        $display("%0t: overflow expected %b actual %b", $time,
                                 want.ovf, o_overflow);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                exp_due.push_back(taylor_predict(i_x_value));

            if (exp_due.size() == 0 && !i_in_valid)
                idle_cycles++;
            else
                idle_cycles = 0;

            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                stuck = 0;
            else
                stuck++;
            if (stuck >= WATCHDOG_CYCLES) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int unsigned nt;
        int unsigned eps;
        int unsigned items;
        int unsigned sel;

        // reset settings: zero, extremes, one, overflow edge, alternating bits
        add_x('0);
        add_x(X_MAX);
        add_x(X_W'(1));
        add_x(X_W'(1) << X_FRAC_BITS);
        add_x(X_W'(32'h58B9_0BFC));
        add_x(X_W'(32'h5555_5555));
        add_x(X_W'(32'h2AAA_AAAA));
        // zero n_terms counts as one
        add_cfg(CFG_N_TERMS, 0);
        add_x(X_W'(1) << X_FRAC_BITS);
        add_x(X_MAX);
        add_cfg(CFG_N_TERMS, 1);
        add_x(X_MAX);
        // more terms than the count cap
        add_cfg(CFG_N_TERMS, 127);
        add_x(X_MAX);
        add_x(X_W'(32'h4000_0000));
        // threshold of zero: only a term of zero meets it
        add_cfg(CFG_N_TERMS, 64);
        add_cfg(CFG_EPS, 0);
        add_x(X_MAX);
        add_x('0);
        add_x(X_W'(1));
        // threshold of one and above: leading term already meets it
        add_cfg(CFG_EPS, 32'h100_0000);
        add_x(X_W'(1) << X_FRAC_BITS);
        add_x('0);
        add_cfg(CFG_EPS, 32'h1FF_FFFF);
        add_x(X_MAX);
        add_cfg(CFG_N_TERMS, 24);
        add_cfg(CFG_EPS, 1);
        add_x(X_W'(32'h3000_0000));
        add_drain();

        // random settings, mostly few terms and a loose threshold to keep items short
        while (x_count < X_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                nt    = $urandom_range(0, 127);
                items = 6;
            end else begin
                nt    = $urandom_range(1, 12);
                items = $urandom_range(20, 60);
            end
            case ($urandom_range(0, 9))
                0: eps = $urandom_range(0, 64);
                1: eps = $urandom() & 32'h1FF_FFFF;
                default: eps = $urandom_range(32'h4000, 32'h100_0000);
            endcase
            add_cfg(CFG_N_TERMS, nt);
            if (sel == 0 || $urandom_range(0, 3) != 0) add_cfg(CFG_EPS, eps);
            repeat (items) begin
                add_x(rand_x());
                if ($urandom_range(0, 99) == 0) add_drain();
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (x_jobs.size() != 0 || i_in_valid || exp_due.size() != 0)
            @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
